// ===== hw/rtl/drexg_pkg.sv =====
// Shared types and constants for the digit run expander.
package drexg_pkg;

  localparam int unsigned GLEN_W  = 4;
  localparam int unsigned GPL_W   = 6;
  localparam int unsigned CFG_W   = 6;
  localparam int unsigned CNT_W   = 4;

  localparam logic [GLEN_W-1:0] GLEN_RESET = 4'd3;
  localparam logic [GPL_W-1:0]  GPL_RESET  = 6'd16;
  localparam logic [CNT_W-1:0]  LAST_SLOT  = 4'd13;  // fourteenth result
  localparam logic [CNT_W-1:0]  MAX_RES    = 4'd14;

  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_DEL  = 8'h7F;

  // register indexes on the configuration port
  localparam logic CFG_GROUP_LENGTH    = 1'b0;
  localparam logic CFG_GROUPS_PER_LINE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEP,
    ST_CHR,
    ST_DOT,
    ST_NL1,
    ST_NL2
  } state_e;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_SEP,
    EM_CHR,
    EM_DOT,
    EM_NL,
    EM_NL_LAST
  } emit_e;

  typedef struct packed {
    logic  load;
    emit_e emit;
  } cmd_t;

  typedef struct packed {
    logic term;       // accepted item ends the message
    logic run;        // accepted item starts a character run
    logic sep_first;  // run opens with a separator
    logic step_ok;    // current emit step may complete
    logic reps_done;  // this character is the last of the run
    logic sep_next;   // next character opens a new group
  } status_t;

endpackage

// ===== hw/rtl/drexg_in_if.sv =====
// Input channel: one character item per handshake.
interface drexg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ===== hw/rtl/drexg_out_if.sv =====
// Output channel: one output byte per handshake.
interface drexg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== hw/rtl/drexg_ctrl.sv =====
// Controller state machine for the digit run expander.
module drexg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  drexg_pkg::status_t status_i,
  output drexg_pkg::cmd_t    cmd_o
);

  drexg_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= drexg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      drexg_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (status_i.term) begin
            state_d = drexg_pkg::ST_DOT;
          end else if (status_i.run) begin
            state_d = status_i.sep_first ? drexg_pkg::ST_SEP : drexg_pkg::ST_CHR;
          end
        end
      end
      drexg_pkg::ST_SEP: begin
        if (status_i.step_ok) state_d = drexg_pkg::ST_CHR;
      end
      drexg_pkg::ST_CHR: begin
        if (status_i.step_ok) begin
          if (status_i.reps_done) begin
            state_d = drexg_pkg::ST_IDLE;
          end else begin
            state_d = status_i.sep_next ? drexg_pkg::ST_SEP : drexg_pkg::ST_CHR;
          end
        end
      end
      drexg_pkg::ST_DOT: begin
        if (status_i.step_ok) state_d = drexg_pkg::ST_NL1;
      end
      drexg_pkg::ST_NL1: begin
        if (status_i.step_ok) state_d = drexg_pkg::ST_NL2;
      end
      drexg_pkg::ST_NL2: begin
        if (status_i.step_ok) state_d = drexg_pkg::ST_IDLE;
      end
      default: state_d = drexg_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o.load  = 1'b0;
    cmd_o.emit  = drexg_pkg::EM_NONE;
    case (state_q)
      drexg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      drexg_pkg::ST_SEP: cmd_o.emit = drexg_pkg::EM_SEP;
      drexg_pkg::ST_CHR: cmd_o.emit = drexg_pkg::EM_CHR;
      drexg_pkg::ST_DOT: cmd_o.emit = drexg_pkg::EM_DOT;
      drexg_pkg::ST_NL1: cmd_o.emit = drexg_pkg::EM_NL;
      drexg_pkg::ST_NL2: cmd_o.emit = drexg_pkg::EM_NL_LAST;
      default: cmd_o.emit = drexg_pkg::EM_NONE;
    endcase
  end

endmodule

// ===== hw/rtl/drexg_dp.sv =====
// Datapath: repeat count, group counters, result count and output register.
module drexg_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [drexg_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic [7:0]                    in_byte_i,
  input  logic                          end_of_input_i,
  input  drexg_pkg::cmd_t               cmd_i,
  output drexg_pkg::status_t            status_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    out_byte_o,
  output logic                          out_last_o
);

  logic [drexg_pkg::GLEN_W-1:0] glen_q;
  logic [drexg_pkg::GPL_W-1:0]  gpl_q;
  logic                         armed_q;
  logic [3:0]                   value_q;
  logic [3:0]                   reps_q;
  logic [7:0]                   ch_q;
  logic [drexg_pkg::GLEN_W-1:0] pos_q;
  logic [drexg_pkg::GPL_W-1:0]  line_q;
  logic                         emitted_q;
  logic [drexg_pkg::CNT_W-1:0]  cnt_q;
  logic                         oval_q;
  logic [7:0]                   obyte_q;
  logic                         olast_q;

  logic                         is_term, is_drop, is_digit, is_arm, is_run;
  logic [drexg_pkg::GLEN_W-1:0] glen_eff;
  logic [drexg_pkg::GPL_W-1:0]  gpl_eff;
  logic [drexg_pkg::GLEN_W:0]   pos_inc;
  logic [drexg_pkg::GPL_W:0]    line_inc;
  logic                         wrap, lwrap;
  logic                         active, suppress, out_free, step_ok, push;
  logic [7:0]                   emit_byte;
  logic                         emit_last;

  // item classification
  assign is_term  = end_of_input_i || (in_byte_i == drexg_pkg::CH_DOT);
  assign is_drop  = !is_term && ((in_byte_i <= drexg_pkg::CH_SP) ||
                                 (in_byte_i == drexg_pkg::CH_DEL));
  assign is_digit = (in_byte_i >= drexg_pkg::CH_ZERO) && (in_byte_i <= drexg_pkg::CH_NINE);
  assign is_arm   = !is_term && !is_drop && is_digit && !armed_q;
  assign is_run   = !is_term && !is_drop && !is_arm;

  // zero limit acts as one
  assign glen_eff = (glen_q == '0) ? drexg_pkg::GLEN_W'(1) : glen_q;
  assign gpl_eff  = (gpl_q == '0)  ? drexg_pkg::GPL_W'(1)  : gpl_q;
  assign pos_inc  = {1'b0, pos_q} + (drexg_pkg::GLEN_W+1)'(1);
  assign line_inc = {1'b0, line_q} + (drexg_pkg::GPL_W+1)'(1);
  assign wrap     = pos_inc >= {1'b0, glen_eff};
  assign lwrap    = line_inc >= {1'b0, gpl_eff};

  assign active   = (cmd_i.emit != drexg_pkg::EM_NONE);
  assign suppress = (cnt_q >= drexg_pkg::MAX_RES);
  assign out_free = !oval_q || out_ready_i;
  assign step_ok  = suppress || out_free;
  assign push     = active && !suppress && out_free;

  always_comb begin
    emit_byte = ch_q;
    emit_last = 1'b0;
    case (cmd_i.emit)
      drexg_pkg::EM_SEP: begin
        emit_byte = (line_q == '0) ? drexg_pkg::CH_NL : drexg_pkg::CH_SP;
        emit_last = (cnt_q == drexg_pkg::LAST_SLOT);
      end
      drexg_pkg::EM_CHR: begin
        emit_byte = ch_q;
        emit_last = (reps_q == '0) || (cnt_q == drexg_pkg::LAST_SLOT);
      end
      drexg_pkg::EM_DOT:     emit_byte = drexg_pkg::CH_DOT;
      drexg_pkg::EM_NL:      emit_byte = drexg_pkg::CH_NL;
      drexg_pkg::EM_NL_LAST: begin
        emit_byte = drexg_pkg::CH_NL;
        emit_last = 1'b1;
      end
      default: begin
        emit_byte = ch_q;
        emit_last = 1'b0;
      end
    endcase
  end

  assign status_o.term      = is_term;
  assign status_o.run       = is_run;
  assign status_o.sep_first = emitted_q && (pos_q == '0);
  assign status_o.step_ok   = step_ok;
  assign status_o.reps_done = (reps_q == '0);
  assign status_o.sep_next  = wrap;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glen_q <= drexg_pkg::GLEN_RESET;
      gpl_q  <= drexg_pkg::GPL_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == drexg_pkg::CFG_GROUP_LENGTH) begin
        glen_q <= cfg_data_i[drexg_pkg::GLEN_W-1:0];
      end else begin
        gpl_q <= cfg_data_i[drexg_pkg::GPL_W-1:0];
      end
    end
  end

  // message state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q   <= 1'b0;
      value_q   <= '0;
      reps_q    <= '0;
      pos_q     <= '0;
      line_q    <= '0;
      emitted_q <= 1'b0;
      cnt_q     <= '0;
    end else if (cmd_i.load) begin
      if (is_term) begin
        armed_q   <= 1'b0;
        value_q   <= '0;
        pos_q     <= '0;
        line_q    <= '0;
        emitted_q <= 1'b0;
        cnt_q     <= '0;
      end else if (is_arm) begin
        armed_q <= 1'b1;
        value_q <= in_byte_i[3:0];
      end else if (is_run) begin
        reps_q  <= armed_q ? value_q : 4'd0;
        armed_q <= 1'b0;
        value_q <= '0;
        cnt_q   <= '0;
      end
    end else begin
      if (push) cnt_q <= cnt_q + drexg_pkg::CNT_W'(1);
      if ((cmd_i.emit == drexg_pkg::EM_CHR) && step_ok) begin
        emitted_q <= 1'b1;
        if (reps_q != '0) reps_q <= reps_q - 4'd1;
        if (wrap) begin
          pos_q  <= '0;
          line_q <= lwrap ? '0 : line_inc[drexg_pkg::GPL_W-1:0];
        end else begin
          pos_q <= pos_inc[drexg_pkg::GLEN_W-1:0];
        end
      end
    end
  end

  // latched character and output byte, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && is_run) ch_q <= in_byte_i;
    if (push) begin
      obyte_q <= emit_byte;
      olast_q <= emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oval_q <= 1'b0;
    end else if (push) begin
      oval_q <= 1'b1;
    end else if (out_ready_i) begin
      oval_q <= 1'b0;
    end
  end

  assign out_valid_o = oval_q;
  assign out_byte_o  = obyte_q;
  assign out_last_o  = olast_q;

endmodule

// ===== hw/rtl/digit_run_expander_grouped.sv =====
// Top level of the digit-prefixed run-length expander with grouped output.
//
// Channels: in_s carries one character item (in_byte, end_of_input); out_s
// carries one output byte per handshake with last set on the final byte that an
// input item causes. Configuration: cfg_we_i writes group_length (index 0)
// or groups_per_line (index 1) from cfg_data_i; write only while idle.
// After an item is taken, the sequencer state register moves to its first emit
// state and the output register then captures the first byte once it is free.
// A dropped byte or a repeat digit leaves the sequencer idle; otherwise it
// emits the generated bytes (characters, separators, terminator) in turn before
// it takes the next item. Bytes past the fourteenth are discarded but still step
// the group counters, one a cycle. The single output register sets the pace:
// one byte per cycle at most. Input is taken only between items; an item with
// no output frees the input again on the next cycle, and a new item may be
// taken while the last byte still waits in the output register.
// Receiver stall: the sequencer holds and no byte is lost or repeated.
// Reset: counters, repeat count and message state clear; group_length
// returns to 3 and groups_per_line to 16.
module digit_run_expander_grouped (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  drexg_in_if.sink                    in_s,
  drexg_out_if.source                 out_s,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [drexg_pkg::CFG_W-1:0] cfg_data_i
);

  drexg_pkg::cmd_t    cmd;
  drexg_pkg::status_t status;
  logic               in_ready;

  assign in_s.ready = in_ready;

  // sequencer: an idle state and one state per emit step
  drexg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_s.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // counters, latched character and output register
  drexg_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_byte_i      (in_s.in_byte),
    .end_of_input_i (in_s.end_of_input),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_s.valid),
    .out_ready_i    (out_s.ready),
    .out_byte_o     (out_s.out_byte),
    .out_last_o     (out_s.last)
  );

endmodule

// ===== hw/rtl/drexg_checker.sv =====
// Port-level checks for the digit run expander, bound to the top level.
module drexg_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [7:0] in_byte_i,
  input logic       end_of_input_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i
);

  logic in_take;
  assign in_take = in_valid_i && in_ready_i;

  // a stalled output byte holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i))
    else $error("output byte changed while stalled");

  // a terminator keeps the input closed while it is emitted
  a_term_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && end_of_input_i |=> !in_ready_i)
    else $error("input taken during terminator");

  // a dropped control code frees the input at once
  a_drop_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && !end_of_input_i && ((in_byte_i <= 8'h20) || (in_byte_i == 8'h7F))
    |=> in_ready_i)
    else $error("dropped byte stalled the input");

  // a terminator taken while the output is free produces a period as the next byte
  a_term_dot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && end_of_input_i && (!out_valid_i || out_ready_i)
    |-> ##2 out_valid_i && (out_byte_i == 8'h2E))
    else $error("terminator did not start with a period");

endmodule

bind digit_run_expander_grouped drexg_checker u_drexg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_s.valid),
  .in_ready_i     (in_s.ready),
  .in_byte_i      (in_s.in_byte),
  .end_of_input_i (in_s.end_of_input),
  .out_valid_i    (out_s.valid),
  .out_ready_i    (out_s.ready),
  .out_byte_i     (out_s.out_byte)
);
